>>> rtl/core/char_framebuffer_rect_outline_defines.svh
// ----------------------------------------------------------------------------
// char_framebuffer_rect_outline assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef CHAR_FRAMEBUFFER_RECT_OUTLINE_DEFINES_SVH
`define CHAR_FRAMEBUFFER_RECT_OUTLINE_DEFINES_SVH

// property checked outside reset
`define CFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define CFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// constants, codes and controller/datapath link types for the frame store
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int WIDTH   = 50;
  localparam int HEIGHT  = 20;
  localparam int CELLS   = WIDTH * HEIGHT;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CHAR_W  = 8;
  localparam int COORD_W = 8;
  localparam int FUNC_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_PLOT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RECT = 2'd2;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'd46;
  localparam logic [CHAR_W-1:0] MARK_CHAR  = 8'd120;

  // write/read address source
  localparam logic [2:0] WSEL_CLEAR = 3'd0;
  localparam logic [2:0] WSEL_POINT = 3'd1;
  localparam logic [2:0] WSEL_ROW_A = 3'd2;
  localparam logic [2:0] WSEL_ROW_B = 3'd3;
  localparam logic [2:0] WSEL_COL_A = 3'd4;
  localparam logic [2:0] WSEL_COL_B = 3'd5;

  typedef struct packed {
    logic       load;
    logic       wr;
    logic [2:0] wsel;
    logic       rd;
    logic       cnt_row;
    logic       cnt_col;
    logic       cnt_inc;
    logic       clr_inc;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              row_none;
    logic              col_none;
    logic              row_last;
    logic              col_last;
    logic              clr_last;
    logic              out_busy;
  } sts_t;

endpackage

>>> rtl/core/cfr_if.sv
// ----------------------------------------------------------------------------
// cfr_req_if / cfr_rsp_if
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface cfr_req_if;
  logic                           valid;
  logic                           ready;
  logic [cfr_pkg::FUNC_W-1:0]     func;
  logic [cfr_pkg::COORD_W-1:0]    x_a;
  logic [cfr_pkg::COORD_W-1:0]    y_a;
  logic [cfr_pkg::COORD_W-1:0]    x_b;
  logic [cfr_pkg::COORD_W-1:0]    y_b;
  logic [cfr_pkg::CHAR_W-1:0]     char_value;

  modport source (output valid, func, x_a, y_a, x_b, y_b, char_value, input ready);
  modport sink   (input valid, func, x_a, y_a, x_b, y_b, char_value, output ready);
endinterface

interface cfr_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [cfr_pkg::CHAR_W-1:0] read_char;
  logic                       in_range;

  modport source (output valid, read_char, in_range, input ready);
  modport sink   (input valid, read_char, in_range, output ready);
endinterface

>>> rtl/core/cfr_ram.sv
// ----------------------------------------------------------------------------
// cfr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/cfr_ctrl.sv
// ----------------------------------------------------------------------------
// cfr_ctrl
// sequencer for clearing, plot, read and rectangle outline walks
// ----------------------------------------------------------------------------
module cfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfr_pkg::sts_t sts,
  output cfr_pkg::cmd_t cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_EXEC     = 4'd2;
  localparam logic [3:0] S_ROW_A    = 4'd3;
  localparam logic [3:0] S_ROW_B    = 4'd4;
  localparam logic [3:0] S_COL_INIT = 4'd5;
  localparam logic [3:0] S_COL_A    = 4'd6;
  localparam logic [3:0] S_COL_B    = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.wr      = 1'b1;
        cmd.wsel    = cfr_pkg::WSEL_CLEAR;
        cmd.clr_inc = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.wsel = cfr_pkg::WSEL_POINT;
        unique case (sts.func)
          cfr_pkg::FUNC_PLOT: begin
            cmd.wr    = 1'b1;
            state_nxt = S_DONE;
          end
          cfr_pkg::FUNC_READ: begin
            cmd.rd    = 1'b1;
            state_nxt = S_DONE;
          end
          cfr_pkg::FUNC_RECT: begin
            cmd.cnt_row = 1'b1;
            state_nxt   = sts.row_none ? S_COL_INIT : S_ROW_A;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_ROW_A: begin
        cmd.wr    = 1'b1;
        cmd.wsel  = cfr_pkg::WSEL_ROW_A;
        state_nxt = S_ROW_B;
      end
      S_ROW_B: begin
        cmd.wr   = 1'b1;
        cmd.wsel = cfr_pkg::WSEL_ROW_B;
        if (sts.row_last) begin
          state_nxt = S_COL_INIT;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_ROW_A;
        end
      end
      S_COL_INIT: begin
        cmd.cnt_col = 1'b1;
        state_nxt   = sts.col_none ? S_DONE : S_COL_A;
      end
      S_COL_A: begin
        cmd.wr    = 1'b1;
        cmd.wsel  = cfr_pkg::WSEL_COL_A;
        state_nxt = S_COL_B;
      end
      S_COL_B: begin
        cmd.wr   = 1'b1;
        cmd.wsel = cfr_pkg::WSEL_COL_B;
        if (sts.col_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_COL_A;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/core/cfr_dp.sv
// ----------------------------------------------------------------------------
// cfr_dp
// command registers, walk counter, cell addressing, frame store and result
// ----------------------------------------------------------------------------
module cfr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfr_pkg::cmd_t                 cmd,
  output cfr_pkg::sts_t                 sts,
  input  logic [cfr_pkg::FUNC_W-1:0]    in_func,
  input  logic [cfr_pkg::COORD_W-1:0]   in_x_a,
  input  logic [cfr_pkg::COORD_W-1:0]   in_y_a,
  input  logic [cfr_pkg::COORD_W-1:0]   in_x_b,
  input  logic [cfr_pkg::COORD_W-1:0]   in_y_b,
  input  logic [cfr_pkg::CHAR_W-1:0]    in_char_value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [cfr_pkg::CHAR_W-1:0]    out_read_char,
  output logic                          out_in_range
);

  localparam int PROD_W = 2 * cfr_pkg::COORD_W;
  localparam logic [cfr_pkg::COORD_W-1:0] X_LIM  = cfr_pkg::COORD_W'(cfr_pkg::WIDTH);
  localparam logic [cfr_pkg::COORD_W-1:0] Y_LIM  = cfr_pkg::COORD_W'(cfr_pkg::HEIGHT);
  localparam logic [cfr_pkg::COORD_W-1:0] X_MAX  = cfr_pkg::COORD_W'(cfr_pkg::WIDTH - 1);
  localparam logic [cfr_pkg::COORD_W-1:0] Y_MAX  = cfr_pkg::COORD_W'(cfr_pkg::HEIGHT - 1);
  localparam logic [cfr_pkg::ADDR_W-1:0]  A_LAST = cfr_pkg::ADDR_W'(cfr_pkg::CELLS - 1);

  logic [cfr_pkg::FUNC_W-1:0]  func_r;
  logic [cfr_pkg::COORD_W-1:0] xa_r;
  logic [cfr_pkg::COORD_W-1:0] ya_r;
  logic [cfr_pkg::COORD_W-1:0] xb_r;
  logic [cfr_pkg::COORD_W-1:0] yb_r;
  logic [cfr_pkg::CHAR_W-1:0]  ch_r;
  logic [cfr_pkg::COORD_W-1:0] cnt_r;
  logic [cfr_pkg::ADDR_W-1:0]  clr_addr_r;
  logic                        out_valid_r;
  logic [cfr_pkg::CHAR_W-1:0]  out_char_r;
  logic                        out_range_r;

  logic [cfr_pkg::COORD_W-1:0] wx;
  logic [cfr_pkg::COORD_W-1:0] wy;
  logic [cfr_pkg::CHAR_W-1:0]  wdata;
  logic [PROD_W-1:0]           addr_full;
  logic [cfr_pkg::ADDR_W-1:0]  addr;
  logic                        w_on;
  logic                        pt_on;
  logic                        we;
  logic                        re;
  logic [cfr_pkg::CHAR_W-1:0]  rdata;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      xa_r   <= in_x_a;
      ya_r   <= in_y_a;
      xb_r   <= in_x_b;
      yb_r   <= in_y_b;
      ch_r   <= in_char_value;
    end
    if (cmd.cnt_row) begin
      cnt_r <= xa_r;
    end else if (cmd.cnt_col) begin
      cnt_r <= ya_r;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_char_r  <= (func_r == cfr_pkg::FUNC_READ && pt_on) ? rdata : '0;
      out_range_r <= (func_r == cfr_pkg::FUNC_RECT) ||
                     ((func_r == cfr_pkg::FUNC_PLOT || func_r == cfr_pkg::FUNC_READ) && pt_on);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_inc) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // cell coordinate and data for the current access
  always_comb begin
    wx    = xa_r;
    wy    = ya_r;
    wdata = cfr_pkg::MARK_CHAR;
    unique case (cmd.wsel)
      cfr_pkg::WSEL_CLEAR: wdata = cfr_pkg::BLANK_CHAR;
      cfr_pkg::WSEL_POINT: wdata = ch_r;
      cfr_pkg::WSEL_ROW_A: wx = cnt_r;
      cfr_pkg::WSEL_ROW_B: begin
        wx = cnt_r;
        wy = yb_r;
      end
      cfr_pkg::WSEL_COL_A: wy = cnt_r;
      cfr_pkg::WSEL_COL_B: begin
        wx = xb_r;
        wy = cnt_r;
      end
      default: wdata = cfr_pkg::MARK_CHAR;
    endcase
  end

  assign w_on      = (wx < X_LIM) && (wy < Y_LIM);
  assign pt_on     = (xa_r < X_LIM) && (ya_r < Y_LIM);
  assign addr_full = PROD_W'(wy) * PROD_W'(cfr_pkg::WIDTH) + PROD_W'(wx);
  assign addr      = (cmd.wsel == cfr_pkg::WSEL_CLEAR) ? clr_addr_r
                                                      : addr_full[cfr_pkg::ADDR_W-1:0];
  assign we        = cmd.wr && ((cmd.wsel == cfr_pkg::WSEL_CLEAR) || w_on);
  assign re        = cmd.rd && pt_on;

  cfr_ram #(
    .DATA_W (cfr_pkg::CHAR_W),
    .DEPTH  (cfr_pkg::CELLS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .re    (re),
    .raddr (addr),
    .rdata (rdata)
  );

  always_comb begin
    sts          = '0;
    sts.func     = func_r;
    sts.row_none = (xa_r > xb_r) || (xa_r >= X_LIM);
    sts.col_none = (ya_r > yb_r) || (ya_r >= Y_LIM);
    sts.row_last = (cnt_r == xb_r) || (cnt_r == X_MAX);
    sts.col_last = (cnt_r == yb_r) || (cnt_r == Y_MAX);
    sts.clr_last = (clr_addr_r == A_LAST);
    sts.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_read_char = out_char_r;
  assign out_in_range  = out_range_r;

endmodule

>>> rtl/core/char_framebuffer_rect_outline.sv
// ----------------------------------------------------------------------------
// char_framebuffer_rect_outline
// character frame store with plot, read and rectangle outline commands
//
//   channel   dir   payload                                  transaction
//   in_chan   in    func, x_a, y_a, x_b, y_b, char_value     valid & ready
//   out_chan  out   read_char, in_range                      valid & ready
//
// plot writes and read reads the cell in the execute state, then the result is loaded into the output register
// rectangle writes top and bottom edge cells along the on-screen columns, then left
// and right edge cells along the on-screen rows, through one frame store write port
// after reset the store is cleared to '.' one cell a cycle, all CELLS (1000)
// cells, during which in_chan.ready stays low
// a stalled result waits in the output register while the next command is
// taken; it completes once that register is free
// ----------------------------------------------------------------------------
module char_framebuffer_rect_outline (
  input  logic      clk,
  input  logic      rst_n,
  cfr_req_if.sink   in_chan,
  cfr_rsp_if.source out_chan
);

  cfr_pkg::cmd_t cmd;
  cfr_pkg::sts_t sts;

  cfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_chan.func),
    .in_x_a        (in_chan.x_a),
    .in_y_a        (in_chan.y_a),
    .in_x_b        (in_chan.x_b),
    .in_y_b        (in_chan.y_b),
    .in_char_value (in_chan.char_value),
    .out_ready     (out_chan.ready),
    .out_valid     (out_chan.valid),
    .out_read_char (out_chan.read_char),
    .out_in_range  (out_chan.in_range)
  );

endmodule

>>> rtl/core/cfr_checker.sv
// ----------------------------------------------------------------------------
// cfr_checker
// port-level checks on the frame store, bound to the top level
// ----------------------------------------------------------------------------
`include "char_framebuffer_rect_outline_defines.svh"

module cfr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cfr_pkg::CHAR_W-1:0] read_char,
  input logic                       in_range
);

  logic [1:0]                pending_r;
  logic                      in_fire;
  logic                      out_fire;
  logic                      out_stall;
  logic [cfr_pkg::CHAR_W:0]  out_word;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_word  = {read_char, in_range};

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 2'(in_fire) - 2'(out_fire);
    end
  end

  `CFR_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_word), "stalled result changed")
  `CFR_ASSERT(a_pending_max, pending_r != 2'd3, "more than two transactions in flight")
  `CFR_ASSERT(a_out_owed, out_valid |-> pending_r != 2'd0, "result without a command")
  `CFR_ASSERT(a_char_range, out_valid && |read_char |-> in_range, "character off screen")
  `CFR_ASSERT_ALWAYS(a_clear_busy, !rst_n |=> !in_ready, "command taken during clearing")

endmodule

bind char_framebuffer_rect_outline cfr_checker u_cfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .read_char (out_chan.read_char),
  .in_range  (out_chan.in_range)
);
